// ===== design/lruev_pkg.sv =====
// Shared types and constants for the LRU evictor with use counts.
package lruev_pkg;

    localparam int ENTRIES = 32;
    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int CNT_W   = SLOT_W + 1;
    localparam int KEY_W   = 32;
    localparam int USE_W   = 16;
    localparam int LIMIT_W = 6;
    localparam int FUNC_W  = 2;
    localparam int KIND_W  = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(16);
    localparam logic [USE_W-1:0]   USE_MAX   = {USE_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FN_LOCATE = 2'd0,
        FN_FINISH = 2'd1,
        FN_DEACT  = 2'd2
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        K_HIT     = 3'd0,
        K_CREATED = 3'd1,
        K_REFUSED = 3'd2,
        K_FULL    = 3'd3,
        K_EVICTED = 3'd4,
        K_DONE    = 3'd5
    } kind_t;

    typedef struct packed {
        func_t             func;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot;
        logic              create_ok;
    } cmd_t;

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic [USE_W-1:0]  use_count;
        logic              last;
    } res_t;

endpackage

// ===== design/lruev_front.sv =====
// Front end: accept and classify requests, queue them for the back end.
module lruev_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lruev_pkg::FUNC_W-1:0] s_func,
    input  logic [lruev_pkg::KEY_W-1:0]  s_key,
    input  logic [lruev_pkg::SLOT_W-1:0] s_slot,
    input  logic                         s_create_ok,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output lruev_pkg::cmd_t              cmd
);

    lruev_pkg::cmd_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       known, push, pop;

    // Drop requests with an unknown function code.
    always_comb begin
        case (lruev_pkg::func_t'(s_func))
            lruev_pkg::FN_LOCATE, lruev_pkg::FN_FINISH, lruev_pkg::FN_DEACT: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    assign s_ready   = (cnt_reg != 2'd2);
    assign push      = s_valid && s_ready && known;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg].func      <= lruev_pkg::func_t'(s_func);
            q_reg[wr_ptr_reg].key       <= s_key;
            q_reg[wr_ptr_reg].slot      <= s_slot;
            q_reg[wr_ptr_reg].create_ok <= s_create_ok;
        end
    end

endmodule

// ===== design/lruev_back.sv =====
// Back end: table lookup, LRU update, use counts and eviction scan.
module lruev_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lruev_pkg::LIMIT_W-1:0] entry_limit,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  lruev_pkg::cmd_t               cmd,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lruev_pkg::res_t               res
);

    localparam int E = lruev_pkg::ENTRIES;
    localparam int SW = lruev_pkg::SLOT_W;
    localparam int CW = lruev_pkg::CNT_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOOK  = 9'b000000010,
        S_LRES  = 9'b000000100,
        S_FRD   = 9'b000001000,
        S_FDEC  = 9'b000010000,
        S_SINIT = 9'b000100000,
        S_SFIND = 9'b001000000,
        S_SACT  = 9'b010000000,
        S_SDONE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    lruev_pkg::cmd_t cmd_reg, cmd_next;
    logic [E-1:0]  valid_reg, valid_next;
    logic [SW-1:0] rank_reg [E];
    logic [SW-1:0] rank_next [E];
    logic [CW-1:0] total_reg, total_next;
    logic          draining_reg, draining_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          free_found_reg, free_found_next;
    logic [SW-1:0] free_slot_reg, free_slot_next;
    logic          hit_reg, hit_next;
    logic [SW-1:0] tgt_reg, tgt_next;
    logic [lruev_pkg::USE_W-1:0] use_hold_reg, use_hold_next;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          m_valid_reg, m_valid_next;
    lruev_pkg::res_t res_reg, res_next;

    logic [lruev_pkg::KEY_W-1:0] key_mem [E];
    logic [lruev_pkg::USE_W-1:0] use_mem [E];
    logic [lruev_pkg::KEY_W-1:0] key_rd_reg;
    logic [lruev_pkg::USE_W-1:0] use_rd_reg;
    logic [SW-1:0] rd_addr, wr_addr;
    logic          key_we, use_we;
    logic [lruev_pkg::KEY_W-1:0] key_wdata;
    logic [lruev_pkg::USE_W-1:0] use_wdata;

    logic          out_load;
    logic [SW-1:0] cmp_idx;
    logic          match;
    logic [CW-1:0] lim;
    logic [SW-1:0] tgt_rank;
    logic [SW-1:0] hit_rank;
    logic [SW-1:0] scan_slot;

    assign out_load  = !m_valid_reg || m_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign res       = res_reg;
    assign cmp_idx   = idx_reg[SW-1:0] - SW'(1);
    assign match     = (idx_reg != '0) && valid_reg[cmp_idx] && (key_rd_reg == cmd_reg.key);
    assign lim       = draining_reg ? '0 : CW'(entry_limit);
    assign tgt_rank  = SW'(r_reg - CW'(1));
    assign hit_rank  = rank_reg[tgt_reg];

    // Slot holding the target rank; exactly one valid entry matches.
    always_comb begin
        scan_slot = '0;
        for (int i = 0; i < E; i++) begin
            if (valid_reg[i] && rank_reg[i] == tgt_rank) scan_slot = scan_slot | SW'(i);
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        valid_next      = valid_reg;
        rank_next       = rank_reg;
        total_next      = total_reg;
        draining_next   = draining_reg;
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        hit_next        = hit_reg;
        tgt_next        = tgt_reg;
        use_hold_next   = use_hold_reg;
        r_next          = r_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        res_next        = res_reg;
        rd_addr         = '0;
        wr_addr         = '0;
        key_we          = 1'b0;
        use_we          = 1'b0;
        key_wdata       = cmd_reg.key;
        use_wdata       = '0;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_next = cmd;
                    case (cmd.func)
                        lruev_pkg::FN_LOCATE: begin
                            idx_next        = '0;
                            free_found_next = 1'b0;
                            state_next      = S_LOOK;
                        end
                        lruev_pkg::FN_FINISH: state_next = S_FRD;
                        lruev_pkg::FN_DEACT: begin
                            draining_next = 1'b1;
                            state_next    = S_SINIT;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_LOOK: begin
                rd_addr = idx_reg[SW-1:0];
                if (idx_reg != CW'(E) && !free_found_reg && !valid_reg[idx_reg[SW-1:0]]) begin
                    free_found_next = 1'b1;
                    free_slot_next  = idx_reg[SW-1:0];
                end
                if (match) begin
                    hit_next      = 1'b1;
                    tgt_next      = cmp_idx;
                    use_hold_next = use_rd_reg;
                    state_next    = S_LRES;
                end else if (idx_reg == CW'(E)) begin
                    hit_next   = 1'b0;
                    state_next = S_LRES;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_LRES: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    res_next     = '0;
                    res_next.last = 1'b1;
                    state_next   = S_IDLE;
                    if (hit_reg) begin
                        for (int i = 0; i < E; i++) begin
                            if (valid_reg[i] && rank_reg[i] < hit_rank)
                                rank_next[i] = rank_reg[i] + SW'(1);
                        end
                        rank_next[tgt_reg] = '0;
                        use_wdata = (use_hold_reg == lruev_pkg::USE_MAX) ? use_hold_reg
                                                                         : use_hold_reg + 1'b1;
                        use_we    = 1'b1;
                        wr_addr   = tgt_reg;
                        res_next.kind      = lruev_pkg::K_HIT;
                        res_next.slot      = tgt_reg;
                        res_next.key       = cmd_reg.key;
                        res_next.use_count = use_wdata;
                    end else if (!cmd_reg.create_ok) begin
                        res_next.kind = lruev_pkg::K_REFUSED;
                    end else if (!free_found_reg) begin
                        res_next.kind = lruev_pkg::K_FULL;
                    end else begin
                        for (int i = 0; i < E; i++) begin
                            if (valid_reg[i]) rank_next[i] = rank_reg[i] + SW'(1);
                        end
                        rank_next[free_slot_reg]  = '0;
                        valid_next[free_slot_reg] = 1'b1;
                        wr_addr    = free_slot_reg;
                        key_we     = 1'b1;
                        use_we     = 1'b1;
                        use_wdata  = lruev_pkg::USE_W'(1);
                        total_next = total_reg + CW'(1);
                        res_next.kind      = lruev_pkg::K_CREATED;
                        res_next.slot      = free_slot_reg;
                        res_next.key       = cmd_reg.key;
                        res_next.use_count = lruev_pkg::USE_W'(1);
                    end
                end
            end
            S_FRD: begin
                rd_addr    = cmd_reg.slot;
                state_next = S_FDEC;
            end
            S_FDEC: begin
                // Lower the count, saturating at zero; skip free slots.
                if (valid_reg[cmd_reg.slot] && use_rd_reg != '0) begin
                    use_we    = 1'b1;
                    wr_addr   = cmd_reg.slot;
                    use_wdata = use_rd_reg - 1'b1;
                end
                state_next = S_SINIT;
            end
            S_SINIT: begin
                r_next     = total_reg;
                cnt_next   = (total_reg > lim) ? total_reg - lim : '0;
                state_next = S_SFIND;
            end
            S_SFIND: begin
                if (cnt_reg == '0) begin
                    state_next = S_SDONE;
                end else begin
                    tgt_next   = scan_slot;
                    rd_addr    = scan_slot;
                    state_next = S_SACT;
                end
            end
            S_SACT: begin
                // Keep reading the target so its key and count hold through a stall.
                rd_addr = tgt_reg;
                if (use_rd_reg != '0) begin
                    r_next     = r_reg - CW'(1);
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_SFIND;
                end else if (out_load) begin
                    // Evict and close the gap behind it in the recency order.
                    for (int i = 0; i < E; i++) begin
                        if (valid_reg[i] && rank_reg[i] > tgt_rank)
                            rank_next[i] = rank_reg[i] - SW'(1);
                    end
                    valid_next[tgt_reg] = 1'b0;
                    total_next   = total_reg - CW'(1);
                    r_next       = r_reg - CW'(1);
                    cnt_next     = cnt_reg - CW'(1);
                    m_valid_next = 1'b1;
                    res_next           = '0;
                    res_next.kind      = lruev_pkg::K_EVICTED;
                    res_next.slot      = tgt_reg;
                    res_next.key       = key_rd_reg;
                    state_next   = S_SFIND;
                end
            end
            S_SDONE: begin
                if (out_load) begin
                    m_valid_next  = 1'b1;
                    res_next      = '0;
                    res_next.kind = lruev_pkg::K_DONE;
                    res_next.last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            total_reg    <= '0;
            draining_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < E; i++) rank_reg[i] <= '0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            total_reg    <= total_next;
            draining_reg <= draining_next;
            m_valid_reg  <= m_valid_next;
            rank_reg     <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        hit_reg        <= hit_next;
        tgt_reg        <= tgt_next;
        use_hold_reg   <= use_hold_next;
        r_reg          <= r_next;
        cnt_reg        <= cnt_next;
        res_reg        <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (key_we) key_mem[wr_addr] <= key_wdata;
        if (use_we) use_mem[wr_addr] <= use_wdata;
        key_rd_reg <= key_mem[rd_addr];
        use_rd_reg <= use_mem[rd_addr];
    end

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CW'(E))
        else $error("entry total exceeds table size");

    a_scan_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SFIND || state_reg == S_SACT) |-> cnt_reg <= r_reg)
        else $error("scan count runs past LRU end");

    a_act_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SACT && $past(state_reg) != S_SACT) |-> $past(state_reg) == S_SFIND)
        else $error("scan action entered without a find step");

endmodule

// ===== design/lru_evictor_with_pin_counts_top.sv =====
// Top level of the LRU evictor with per-entry use counts.
// Locate: the back end runs a one-port key sweep over up to 32 slots.
// Finish lowers a use count then scans; deactivate drains (limit zero) and scans.
// One request is worked at a time; a two-deep queue takes the next one meanwhile.
// Results stall the back end only when the output register is still occupied.
// aresetn is synchronous, active low: empties the table, clears draining, limit 16.
module lru_evictor_with_pin_counts_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lruev_pkg::FUNC_W-1:0]  s_func,
    input  logic [lruev_pkg::KEY_W-1:0]   s_key,
    input  logic [lruev_pkg::SLOT_W-1:0]  s_slot,
    input  logic                          s_create_ok,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lruev_pkg::KIND_W-1:0]  m_kind,
    output logic [lruev_pkg::SLOT_W-1:0]  m_out_slot,
    output logic [lruev_pkg::KEY_W-1:0]   m_out_key,
    output logic [lruev_pkg::USE_W-1:0]   m_use_count,
    output logic                          m_last,
    input  logic                          cfg_we,
    input  logic [lruev_pkg::LIMIT_W-1:0] cfg_wdata
);

    logic [lruev_pkg::LIMIT_W-1:0] entry_limit_reg;
    logic            cmd_valid, cmd_ready;
    lruev_pkg::cmd_t cmd;
    lruev_pkg::res_t res;

    // Hold the entry limit; the user must write it only while idle, the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_limit_reg <= lruev_pkg::LIMIT_RST;
        end else if (cfg_we) begin
            entry_limit_reg <= cfg_wdata;
        end
    end

    // Front end: take each transaction, drop unknown codes, queue the rest.
    lruev_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_key       (s_key),
        .s_slot      (s_slot),
        .s_create_ok (s_create_ok),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd)
    );

    // Back end: sweep keys, update recency and counts, run the eviction scan.
    lruev_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .entry_limit (entry_limit_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .res         (res)
    );

    // Split the registered result into its fields.
    assign m_kind      = res.kind;
    assign m_out_slot  = res.slot;
    assign m_out_key   = res.key;
    assign m_use_count = res.use_count;
    assign m_last      = res.last;

endmodule
